// ===== rtl/tiled_4bpp_rect_fill_macros.svh =====
// Assertion macros shared by the rectangle fill checker.
`ifndef TILED_4BPP_RECT_FILL_MACROS_SVH
`define TILED_4BPP_RECT_FILL_MACROS_SVH

// Same-cycle implication, off while in reset.
`define T4RF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define T4RF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define T4RF_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/t4rf_pkg.sv =====
// Shared types, codes and constants of the tiled 4bpp rectangle fill block.
package t4rf_pkg;

    localparam int XY_W      = 11;
    localparam int COLOUR_W  = 4;
    localparam int RADDR_W   = 13;
    localparam int TYPE_W    = 3;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 10;   // clipped pixel coordinate, up to 512
    localparam int COL_W     = 7;    // tile column / tile count, up to 64
    localparam int MUL_W     = COL_W + PIX_W;

    typedef logic signed [XY_W:0] t_coord;
    typedef logic [TYPE_W-1:0]    t_req_type;
    typedef logic [2:0]           t_seg;

    localparam t_req_type REQ_READ    = 3'd0;
    localparam t_req_type REQ_FILL    = 3'd1;
    localparam t_req_type REQ_OUTLINE = 3'd2;
    localparam t_req_type REQ_HLINE   = 3'd3;
    localparam t_req_type REQ_VLINE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_WIDTH_RST  = 6'd32;
    localparam logic [CFG_W-1:0]     CFG_HEIGHT_RST = 6'd24;

    // Rectangle segments: whole fill, horizontal edge on top/bottom row,
    // vertical edge on left/right column.
    localparam t_seg SEG_FILL    = 3'd0;
    localparam t_seg SEG_H_TOP   = 3'd1;
    localparam t_seg SEG_H_BOT   = 3'd2;
    localparam t_seg SEG_V_LEFT  = 3'd3;
    localparam t_seg SEG_V_RIGHT = 3'd4;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic seg_setup;
        t_seg seg_code;
        logic base_load;
        logic step;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic empty;
        logic last_word;
        logic out_free;
    } t_ctl_sts;

endpackage

// ===== rtl/t4rf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module t4rf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/t4rf_dpath.sv =====
// Datapath: config, request capture, rectangle clip, word walk, RMW and result.
module t4rf_dpath import t4rf_pkg::*; #(
    parameter int MAX_TILES_WIDE = 32,
    parameter int MAX_TILES_HIGH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl_cmd                    i_cmd,
    output t_ctl_sts                    o_sts,
    input  t_req_type                   i_req_type,
    input  logic signed [XY_W-1:0]      i_xa,
    input  logic signed [XY_W-1:0]      i_ya,
    input  logic signed [XY_W-1:0]      i_xb,
    input  logic signed [XY_W-1:0]      i_yb,
    input  logic [COLOUR_W-1:0]         i_colour,
    input  logic [RADDR_W-1:0]          i_raddr,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [WORD_W-1:0]           o_out_word,
    output logic                        o_out_is_read
);

    localparam int STORE_WORDS = MAX_TILES_WIDE * MAX_TILES_HIGH * 8;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    logic [CFG_W-1:0]          r_cfg_w, r_cfg_h;
    logic signed [XY_W-1:0]    r_xa, r_ya, r_xb, r_yb;
    logic [COLOUR_W-1:0]       r_colour;
    logic [RADDR_W-1:0]        r_raddr;
    logic                      r_rd_oob;
    logic [WORD_W-1:0]         r_res_word;
    logic                      r_res_read;
    logic [PIX_W-1:0]          r_x0, r_x1, r_y0, r_y1;
    logic                      r_empty;
    logic [COL_W-1:0]          r_col, r_last_col;
    logic [PIX_W-1:0]          r_row;
    logic [MUL_W-1:0]          r_base;
    logic                      r_wr_valid;
    logic [ADDR_W-1:0]         r_wr_addr;
    logic [WORD_W-1:0]         r_wr_mask;
    logic [ADDR_W-1:0]         r_clr_cnt;
    logic                      r_out_valid;
    logic [WORD_W-1:0]         r_out_word;
    logic                      r_out_is_read;

    logic [COL_W-1:0]  eff_w, eff_h;
    logic [PIX_W-1:0]  wpix, stride;
    t_coord            xa_e, ya_e, xb_e, yb_e, wpix_s, hpix_s;
    t_coord            x0, x1, y0, y1, x0c, x1c, y0c, y1c;
    logic [PIX_W-1:0]  x1m1;
    logic [MUL_W-1:0]  addr_full;
    logic              last_row;
    logic [3:0]        lo, hi;
    logic [7:0]        nib;
    logic [WORD_W-1:0] mask, pattern, rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata;

    // Registers above the build maximum act as that maximum.
    assign eff_w  = ({1'b0, r_cfg_w} > COL_W'(MAX_TILES_WIDE)) ? COL_W'(MAX_TILES_WIDE)
                                                                : {1'b0, r_cfg_w};
    assign eff_h  = ({1'b0, r_cfg_h} > COL_W'(MAX_TILES_HIGH)) ? COL_W'(MAX_TILES_HIGH)
                                                                : {1'b0, r_cfg_h};
    assign wpix   = {eff_w, 3'b000};
    assign stride = {eff_h, 3'b000};
    assign wpix_s = t_coord'({2'b00, wpix});
    assign hpix_s = t_coord'({2'b00, stride});

    assign xa_e = t_coord'({r_xa[XY_W-1], r_xa});
    assign ya_e = t_coord'({r_ya[XY_W-1], r_ya});
    assign xb_e = t_coord'({r_xb[XY_W-1], r_xb});
    assign yb_e = t_coord'({r_yb[XY_W-1], r_yb});

    // Segment to rectangle, then clip.
    always_comb begin
        t_coord p;
        t_coord one;
        one = t_coord'(1);
        p   = xa_e;
        x0  = '0;
        x1  = '0;
        y0  = '0;
        y1  = '0;
        case (i_cmd.seg_code)
            SEG_FILL: begin
                x0 = xa_e;
                x1 = xb_e;
                y0 = ya_e;
                y1 = yb_e;
            end
            SEG_H_TOP, SEG_H_BOT: begin
                p  = (i_cmd.seg_code == SEG_H_TOP) ? ya_e : yb_e - one;
                x0 = (xb_e < xa_e) ? xb_e : xa_e;
                x1 = (xb_e < xa_e) ? xa_e : xb_e;
                y0 = p;
                y1 = p + one;
            end
            SEG_V_LEFT, SEG_V_RIGHT: begin
                p  = (i_cmd.seg_code == SEG_V_LEFT) ? xa_e : xb_e - one;
                x0 = p;
                x1 = p + one;
                y0 = (yb_e < ya_e) ? yb_e : ya_e;
                y1 = (yb_e < ya_e) ? ya_e : yb_e;
            end
            default: begin
                x0 = '0;
                x1 = '0;
            end
        endcase
        x0c = (x0 < t_coord'(0)) ? t_coord'(0) : x0;
        y0c = (y0 < t_coord'(0)) ? t_coord'(0) : y0;
        x1c = (x1 > wpix_s) ? wpix_s : x1;
        y1c = (y1 > hpix_s) ? hpix_s : y1;
    end

    assign x1m1      = r_x1 - PIX_W'(1);
    assign addr_full = r_base + MUL_W'(r_row);
    assign last_row  = (r_row == r_y1 - PIX_W'(1));

    // Nibble mask of the current tile column.
    always_comb begin
        lo = (r_col == r_x0[PIX_W-1:3]) ? {1'b0, r_x0[2:0]} : 4'd0;
        hi = (r_col < r_x1[PIX_W-1:3]) ? 4'd8 : {1'b0, r_x1[2:0]};
        for (int k = 0; k < 8; k++) begin
            nib[k]         = (4'(k) >= lo) && (4'(k) < hi);
            mask[4*k +: 4] = {4{nib[k]}};
        end
    end

    assign pattern   = {8{r_colour}};
    assign ram_we    = i_cmd.clr_step | r_wr_valid;
    assign ram_waddr = i_cmd.clr_step ? r_clr_cnt : r_wr_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : ((rdata & ~r_wr_mask) | (pattern & r_wr_mask));
    assign ram_raddr = i_cmd.rd_issue ? ADDR_W'(r_raddr) : addr_full[ADDR_W-1:0];

    t4rf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_WIDTH_RST;
            r_cfg_h     <= CFG_HEIGHT_RST;
            r_clr_cnt   <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_WIDTH_IDX) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_HEIGHT_IDX) begin
                r_cfg_h <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            r_wr_valid <= i_cmd.step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_xa       <= i_xa;
            r_ya       <= i_ya;
            r_xb       <= i_xb;
            r_yb       <= i_yb;
            r_colour   <= i_colour;
            r_raddr    <= i_raddr;
            r_rd_oob   <= 32'(i_raddr) >= 32'(STORE_WORDS);
            r_res_word <= '0;
            r_res_read <= (i_req_type == REQ_READ);
        end
        if (i_cmd.rd_capture) begin
            r_res_word <= r_rd_oob ? '0 : rdata;
        end
        if (i_cmd.seg_setup) begin
            r_x0    <= x0c[PIX_W-1:0];
            r_x1    <= x1c[PIX_W-1:0];
            r_y0    <= y0c[PIX_W-1:0];
            r_y1    <= y1c[PIX_W-1:0];
            r_empty <= (x0c >= x1c) || (y0c >= y1c);
        end
        if (i_cmd.base_load) begin
            r_col      <= r_x0[PIX_W-1:3];
            r_last_col <= x1m1[PIX_W-1:3];
            r_row      <= r_y0;
            r_base     <= MUL_W'(r_x0[PIX_W-1:3]) * MUL_W'(stride);
        end else if (i_cmd.step) begin
            if (last_row) begin
                r_row  <= r_y0;
                r_col  <= r_col + COL_W'(1);
                r_base <= r_base + MUL_W'(stride);
            end else begin
                r_row <= r_row + PIX_W'(1);
            end
        end
        if (i_cmd.step) begin
            r_wr_addr <= addr_full[ADDR_W-1:0];
            r_wr_mask <= mask;
        end
        if (i_cmd.out_load) begin
            r_out_word    <= r_res_word;
            r_out_is_read <= r_res_read;
        end
    end

    assign o_sts.clr_last  = (r_clr_cnt == ADDR_W'(STORE_WORDS - 1));
    assign o_sts.empty     = r_empty;
    assign o_sts.last_word = last_row && (r_col == r_last_col);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_out_is_read = r_out_is_read;

endmodule

// ===== rtl/t4rf_ctrl.sv =====
// Controller: clear pass, request decode, segment sequencing and result hand-off.
module t4rf_ctrl import t4rf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  t_req_type i_req_type,
    output t_ctl_cmd  o_cmd,
    input  t_ctl_sts  i_sts
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SEG      = 4'd2;
    localparam logic [3:0] S_BASE     = 4'd3;
    localparam logic [3:0] S_RUN      = 4'd4;
    localparam logic [3:0] S_DRAIN    = 4'd5;
    localparam logic [3:0] S_RD_ISSUE = 4'd6;
    localparam logic [3:0] S_RD_WAIT  = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0] r_state, n_state;
    t_seg       r_seg, n_seg;
    logic       r_outline, n_outline;
    logic       more_seg;
    t_seg       seg_after;

    // Outline order: left, right, top, bottom.
    always_comb begin
        case (r_seg)
            SEG_V_LEFT:  seg_after = SEG_V_RIGHT;
            SEG_V_RIGHT: seg_after = SEG_H_TOP;
            default:     seg_after = SEG_H_BOT;
        endcase
    end

    assign more_seg = r_outline && (r_seg != SEG_H_BOT);

    always_comb begin
        n_state   = r_state;
        n_seg     = r_seg;
        n_outline = r_outline;
        o_cmd          = '0;
        o_cmd.seg_code = r_seg;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_outline     = 1'b0;
                    case (i_req_type)
                        REQ_READ: n_state = S_RD_ISSUE;
                        REQ_FILL: begin
                            n_seg   = SEG_FILL;
                            n_state = S_SEG;
                        end
                        REQ_OUTLINE: begin
                            n_seg     = SEG_V_LEFT;
                            n_outline = 1'b1;
                            n_state   = S_SEG;
                        end
                        REQ_HLINE: begin
                            n_seg   = SEG_H_TOP;
                            n_state = S_SEG;
                        end
                        REQ_VLINE: begin
                            n_seg   = SEG_V_LEFT;
                            n_state = S_SEG;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SEG: begin
                o_cmd.seg_setup = 1'b1;
                n_state         = S_BASE;
            end
            S_BASE: begin
                o_cmd.base_load = 1'b1;
                if (!i_sts.empty) begin
                    n_state = S_RUN;
                end else if (more_seg) begin
                    n_seg   = seg_after;
                    n_state = S_SEG;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_word) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last write of the segment lands this cycle
                if (more_seg) begin
                    n_seg   = seg_after;
                    n_state = S_SEG;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_seg     <= SEG_FILL;
            r_outline <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seg     <= n_seg;
            r_outline <= n_outline;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/tiled_4bpp_rect_fill.sv =====
// Top level of the tiled 4bpp rectangle fill engine.
//
// Usage:
//  - s_axis carries one request per transfer: tuser is the request type
//    (read word, fill, outline, horizontal line, vertical line), tdata the
//    coordinates, colour and read address. m_axis returns exactly one result
//    per request: tdata the word read (zero for drawing), tuser set for reads.
//  - The cfg channel writes canvas width (index 0) and height (index 1) in
//    tiles and is always ready; the user must see that it is written only
//    while the engine is idle, which the block itself does not enforce.
//  - One request is worked at a time; s_axis_tready is high only when idle.
//  - Read: the request passes the read-issue, read-wait and response states.
//  - Drawing: each rectangle (four for an outline) passes setup and base-load
//    states, then, if it covers any word, run and drain states; the run loop
//    is one masked read-modify-write of the canvas RAM per cycle, read port
//    and write port working in parallel. The response state comes last.
//  - Reset: the canvas RAM is swept to zero, one word per cycle, over all
//    MAX_TILES_WIDE*MAX_TILES_HIGH*8 words (8192 by default), with
//    s_axis_tready low; configuration writes are still taken.
//  - Receiver stall: the result waits in the output register; the next
//    request is still accepted and worked, and only its result hand-off waits.
module tiled_4bpp_rect_fill import t4rf_pkg::*; #(
    parameter int MAX_TILES_WIDE = 32,
    parameter int MAX_TILES_HIGH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [10:0] x_first, [21:11] y_first, [32:22] x_second, [43:33] y_second,
    // [47:44] colour, [60:48] read_address, [63:61] zero
    input  logic [63:0]          s_axis_tdata,
    // [2:0] req_type
    input  logic [TYPE_W-1:0]    s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] read_word
    output logic [WORD_W-1:0]    m_axis_tdata,
    // [0] is_read_reply
    output logic                 m_axis_tuser,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int XA_LSB = 0;
    localparam int YA_LSB = XA_LSB + XY_W;
    localparam int XB_LSB = YA_LSB + XY_W;
    localparam int YB_LSB = XB_LSB + XY_W;
    localparam int CO_LSB = YB_LSB + XY_W;
    localparam int RA_LSB = CO_LSB + COLOUR_W;

    t_ctl_cmd               cmd;
    t_ctl_sts               sts;
    logic signed [XY_W-1:0] req_xa, req_ya, req_xb, req_yb;

    assign req_xa = s_axis_tdata[XA_LSB +: XY_W];
    assign req_ya = s_axis_tdata[YA_LSB +: XY_W];
    assign req_xb = s_axis_tdata[XB_LSB +: XY_W];
    assign req_yb = s_axis_tdata[YB_LSB +: XY_W];

    // Registers are plain flops; a write never stalls.
    assign o_cfg_ready = 1'b1;

    t4rf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    t4rf_dpath #(
        .MAX_TILES_WIDE (MAX_TILES_WIDE),
        .MAX_TILES_HIGH (MAX_TILES_HIGH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (s_axis_tuser),
        .i_xa          (req_xa),
        .i_ya          (req_ya),
        .i_xb          (req_xb),
        .i_yb          (req_yb),
        .i_colour      (s_axis_tdata[CO_LSB +: COLOUR_W]),
        .i_raddr       (s_axis_tdata[RA_LSB +: RADDR_W]),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_word    (m_axis_tdata),
        .o_out_is_read (m_axis_tuser)
    );

endmodule

// ===== rtl/t4rf_checker.sv =====
// Port-level checker for the rectangle fill engine, bound to the top level.
`include "tiled_4bpp_rect_fill_macros.svh"

module t4rf_checker import t4rf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [WORD_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tuser
);

    logic s_req_acc;
    logic m_stall;
    logic m_draw;

    assign s_req_acc = s_axis_tvalid && s_axis_tready;
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign m_draw    = m_axis_tvalid && !m_axis_tuser;

    // Reset starts the clear sweep: no request taken, no result shown.
    `T4RF_ASSERT_RST(a_reset_quiet, !i_rst_n, !s_axis_tready && !m_axis_tvalid, "busy in reset")

    // One request in flight: ready drops right after an accepted request.
    `T4RF_ASSERT_NXT(a_one_in_flight, s_req_acc, !s_axis_tready, "second request taken")

    // Drawing completions carry a zero word.
    `T4RF_ASSERT_IMP(a_draw_zero, m_draw, m_axis_tdata == '0, "nonzero draw result")

    // A stalled result is not withdrawn.
    `T4RF_ASSERT_NXT(a_out_hold, m_stall, m_axis_tvalid, "result dropped")

endmodule

bind tiled_4bpp_rect_fill t4rf_checker u_t4rf_checker (.*);

// ===== test/testbench.sv =====
// Testbench of the tiled 4bpp rectangle fill engine against a canvas model.
`timescale 1ns / 100ps

module testbench;
    import t4rf_pkg::*;

    localparam int TILES_WIDE   = 32;
    localparam int TILES_HIGH   = 32;
    localparam int CANVAS_WORDS = TILES_WIDE * TILES_HIGH * 8;
    localparam int IDLE_PCT     = 14;
    // Nothing accepted for this many cycles ends the run; it must outlast the
    // slowest request (a fill of the whole canvas) and the reset sweep.
    localparam int STALL_LIMIT  = 40000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 128;

    // Request types above the last defined one are answered as no-ops.
    localparam t_req_type REQ_UNKNOWN_FIRST = 3'd5;
    localparam t_req_type REQ_UNKNOWN_LAST  = 3'd7;
    // Index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct {
        t_req_type               kind;
        logic signed [XY_W-1:0]  x_first;
        logic signed [XY_W-1:0]  y_first;
        logic signed [XY_W-1:0]  x_second;
        logic signed [XY_W-1:0]  y_second;
        logic [COLOUR_W-1:0]     colour;
        logic [RADDR_W-1:0]      read_address;
    } t_request;

    typedef struct {
        logic [WORD_W-1:0] read_word;
        logic              is_read_reply;
    } t_reply;

    // Settings of the random phases; zero and oversized values included.
    int phase_width [PHASES] = '{32, 1, 7, 0, 63, 20, 32, 33};
    int phase_height[PHASES] = '{32, 1, 13, 24, 40, 0, 5, 63};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;
    logic [TYPE_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_W-1:0]    m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // Canvas model and its register copies.
    logic [WORD_W-1:0] canvas_model [CANVAS_WORDS];
    logic [CFG_W-1:0]  width_tiles_reg;
    logic [CFG_W-1:0]  height_tiles_reg;

    t_request pending_requests[$];   // requests still to be driven
    t_reply   pending_replies[$];    // replies owed by the block, oldest first
    t_request drive_item;            // request currently on s_axis
    logic     req_taken   = 1'b0;    // drive_item accepted at the last rising edge
    logic     calm        = 1'b0;    // no idling on either side
    int       error_count = 0;
    int       stall_cycles = 0;

    tiled_4bpp_rect_fill #(
        .MAX_TILES_WIDE(TILES_WIDE),
        .MAX_TILES_HIGH(TILES_HIGH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Canvas model
    // ---------------------------------------------------------------

    // Registers above the maximum act as the maximum.
    function automatic int eff_width();
        return (width_tiles_reg > TILES_WIDE) ? TILES_WIDE : int'(width_tiles_reg);
    endfunction

    function automatic int eff_height();
        return (height_tiles_reg > TILES_HIGH) ? TILES_HIGH : int'(height_tiles_reg);
    endfunction

    function automatic logic signed [XY_W-1:0] to_coord(input int v);
        return v[XY_W-1:0];
    endfunction

    // Masked read-modify-write of every word that [x0,x1) x [y0,y1) covers.
    function automatic void paint_rect(input int x0, input int y0, input int x1,
                                       input int y1, input logic [COLOUR_W-1:0] c);
        int                wpix;
        int                hpix;
        int                x;
        int                y;
        int                lo;
        int                hi;
        int                base;
        int                a;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] pattern;
        wpix    = eff_width() * 8;
        hpix    = eff_height() * 8;
        pattern = {8{c}};
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > wpix) x1 = wpix;
        if (y1 > hpix) y1 = hpix;
        if (x0 >= x1 || y0 >= y1) return;
        x = x0;
        while (x < x1) begin
            lo = x & 7;
            // full tile unless the span ends inside this tile column
            hi = ((x1 & -8) > (x & -8)) ? 8 : (x1 & 7);
            mask = (32'hFFFF_FFFF << (4 * lo)) & (32'hFFFF_FFFF >> (4 * (8 - hi)));
            base = (x >> 3) * hpix;
            for (y = y0; y < y1; y++) begin
                a = base + y;
                if (a < CANVAS_WORDS)
                    canvas_model[a] = (canvas_model[a] & ~mask) | (pattern & mask);
            end
            x = (x + 8) & -8;
        end
    endfunction

    // Lines take their endpoints in either order.
    function automatic void paint_hline(input int l, input int t, input int r,
                                        input logic [COLOUR_W-1:0] c);
        if (r < l) paint_rect(r, t, l, t + 1, c);
        else       paint_rect(l, t, r, t + 1, c);
    endfunction

    function automatic void paint_vline(input int l, input int t, input int b,
                                        input logic [COLOUR_W-1:0] c);
        if (b < t) paint_rect(l, b, l + 1, t, c);
        else       paint_rect(l, t, l + 1, b, c);
    endfunction

    // Works one accepted request into the model and queues its reply.
    function automatic void apply_request(input t_request r);
        int     xa = r.x_first;
        int     ya = r.y_first;
        int     xb = r.x_second;
        int     yb = r.y_second;
        t_reply want;
        want.read_word     = '0;
        want.is_read_reply = 1'b0;
        case (r.kind)
            REQ_READ: begin
                want.read_word     = canvas_model[r.read_address];
                want.is_read_reply = 1'b1;
            end
            REQ_FILL: begin
                paint_rect(xa, ya, xb, yb, r.colour);
            end
            REQ_OUTLINE: begin
                // left, right, top, bottom
                paint_vline(xa, ya, yb, r.colour);
                paint_vline(xb - 1, ya, yb, r.colour);
                paint_hline(xa, ya, xb, r.colour);
                paint_hline(xa, yb - 1, xb, r.colour);
            end
            REQ_HLINE: begin
                paint_hline(xa, ya, xb, r.colour);
            end
            REQ_VLINE: begin
                paint_vline(xa, ya, yb, r.colour);
            end
            default: begin
            end
        endcase
        pending_replies.push_back(want);
    endfunction

    // ---------------------------------------------------------------
    // Request generation
    // ---------------------------------------------------------------

    function automatic t_request make_request(input t_req_type k, input int xa, input int ya,
                                              input int xb, input int yb, input int c,
                                              input int addr);
        t_request r;
        r.kind         = k;
        r.x_first      = to_coord(xa);
        r.y_first      = to_coord(ya);
        r.x_second     = to_coord(xb);
        r.y_second     = to_coord(yb);
        r.colour       = c[COLOUR_W-1:0];
        r.read_address = addr[RADDR_W-1:0];
        return r;
    endfunction

    // Mostly small rectangles near the canvas, a few large ones, and some
    // requests with every field drawn over its whole range.
    function automatic t_request random_request();
        t_request r;
        int       wpix;
        int       hpix;
        int       span_x;
        int       span_y;
        int       pick;
        int       x0;
        int       y0;
        int       x1;
        int       y1;
        int       px;
        int       py;
        wpix   = eff_width() * 8;
        hpix   = eff_height() * 8;
        span_x = (wpix < 8) ? 8 : wpix;
        span_y = (hpix < 8) ? 8 : hpix;
        pick   = $urandom_range(99);
        x0 = int'($urandom_range(span_x + 16)) - 8;
        y0 = int'($urandom_range(span_y + 16)) - 8;
        if ($urandom_range(99) < 4) begin
            x1 = x0 + int'($urandom_range(span_x + 40)) - 20;
            y1 = y0 + int'($urandom_range(span_y + 40)) - 20;
        end else begin
            x1 = x0 + int'($urandom_range(26)) - 2;
            y1 = y0 + int'($urandom_range(18)) - 2;
        end
        r = make_request(REQ_FILL, x0, y0, x1, y1, $urandom_range(15),
                         $urandom_range(CANVAS_WORDS - 1));
        if (pick < 25) begin
            r.kind = REQ_READ;
            if ($urandom_range(1) == 1) begin
                // aim at a pixel inside the current canvas
                px = $urandom_range(span_x - 1);
                py = $urandom_range(span_y - 1);
                r.read_address = RADDR_W'((px >> 3) * hpix + py);
            end
        end else if (pick < 50) begin
            r.kind = REQ_FILL;
        end else if (pick < 65) begin
            r.kind = REQ_OUTLINE;
        end else if (pick < 77) begin
            r.kind = REQ_HLINE;
        end else if (pick < 89) begin
            r.kind = REQ_VLINE;
        end else if (pick < 92) begin
            r.kind = t_req_type'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
        end else begin
            r.kind     = t_req_type'($urandom_range(REQ_UNKNOWN_LAST));
            r.x_first  = to_coord($urandom_range(2047));
            r.y_first  = to_coord($urandom_range(2047));
            r.x_second = to_coord($urandom_range(2047));
            r.y_second = to_coord($urandom_range(2047));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request driver and acceptance
    // ---------------------------------------------------------------

    // Loads a new request at the falling edge once the current one is gone.
    always @(negedge i_clk) begin : request_driver
        t_request nxt;
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_requests.pop_front();
                drive_item    <= nxt;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, nxt.read_address, nxt.colour, nxt.y_second,
                                  nxt.x_second, nxt.y_first, nxt.x_first};
                s_axis_tuser  <= nxt.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted request goes into the model in acceptance order.
    always @(posedge i_clk) begin : request_accept
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_request(drive_item);
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin : reply_stall
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Reply checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("reply %h/%b with none expected",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tdata !== want.read_word)
                    report_mismatch($sformatf("read_word %h, expected %h",
                                              m_axis_tdata, want.read_word));
                if (m_axis_tuser !== want.is_read_reply)
                    report_mismatch($sformatf("is_read_reply %b, expected %b",
                                              m_axis_tuser, want.is_read_reply));
            end
        end
    end

    // Ends a hung run: counts cycles in which no channel moves anything.
    always @(posedge i_clk) begin : stall_watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Register write; the model takes the value at the accepting edge.
    task automatic write_canvas_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDTH_IDX)
            width_tiles_reg = val;
        else if (idx == CFG_HEIGHT_IDX)
            height_tiles_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Holds the sender until every queued request is taken and answered.
    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || pending_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int p;
        int n;
        for (n = 0; n < CANVAS_WORDS; n++) canvas_model[n] = '0;
        width_tiles_reg  = CFG_WIDTH_RST;
        height_tiles_reg = CFG_HEIGHT_RST;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset canvas: 256 x 192 pixels, stride 192.
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 8191));
        // fill with every coordinate at its extreme
        pending_requests.push_back(make_request(REQ_FILL, -1024, -1024, 1023, 1023, 15, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 8191));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 6143));
        // unaligned span crossing a tile boundary
        pending_requests.push_back(make_request(REQ_FILL, 3, 5, 13, 9, 5, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 5));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 197));
        // empty rectangles: zero width, then inverted corners
        pending_requests.push_back(make_request(REQ_FILL, 10, 10, 10, 20, 2, 0));
        pending_requests.push_back(make_request(REQ_FILL, 20, 9, 10, 5, 2, 0));
        pending_requests.push_back(make_request(REQ_OUTLINE, 2, 4, 30, 20, 9, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 4));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 19));
        // lines with swapped endpoints
        pending_requests.push_back(make_request(REQ_HLINE, 40, 50, 17, 0, 3, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 434));
        pending_requests.push_back(make_request(REQ_VLINE, 60, 90, 0, 70, 12, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 1424));
        // lines clipped away entirely
        pending_requests.push_back(make_request(REQ_HLINE, 0, -1, 255, 0, 1, 0));
        pending_requests.push_back(make_request(REQ_VLINE, -1, 0, 0, 100, 1, 0));
        // last row and last column, clipped at the far side
        pending_requests.push_back(make_request(REQ_HLINE, 250, 191, 1023, 0, 6, 0));
        pending_requests.push_back(make_request(REQ_VLINE, 255, -1024, 0, 1023, 10, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 6143));
        // zero-width outline still draws its right edge one column left
        pending_requests.push_back(make_request(REQ_OUTLINE, 100, 100, 100, 110, 7, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0, 0, 0, 0, 2409));
        // unknown request types change nothing
        for (n = REQ_UNKNOWN_FIRST; n <= REQ_UNKNOWN_LAST; n++)
            pending_requests.push_back(make_request(t_req_type'(n), 1023, -1024, -1024,
                                                    1023, 15, 8191));

        // Random phases, each after the block has gone idle.
        for (p = 0; p < PHASES; p++) begin
            wait_for_idle();
            write_canvas_reg(CFG_WIDTH_IDX, CFG_W'(phase_width[p]));
            write_canvas_reg(CFG_HEIGHT_IDX, CFG_W'(phase_height[p]));
            if (p == 0)
                write_canvas_reg(CFG_SPARE_IDX, 6'h2A);
            calm = (p == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_requests.push_back(random_request());
        end

        wait_for_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/t4rf_pkg.sv
rtl/t4rf_ram.sv
rtl/t4rf_dpath.sv
rtl/t4rf_ctrl.sv
rtl/tiled_4bpp_rect_fill.sv
rtl/t4rf_checker.sv
test/testbench.sv
